/* design/apd_pkg.sv */
// ----------------------------------------------------------------------------
// apd_pkg
// Shared types and constants of the acknowledge packet deframer.
// ----------------------------------------------------------------------------
package apd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned FUNC_W  = 2;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned CSR_INDEX_W = 2;

   // packet layout
   localparam int unsigned POS_HDR0     = 0;
   localparam int unsigned POS_HDR1     = 1;
   localparam int unsigned POS_PID      = 6;
   localparam int unsigned POS_LEN_HI   = 7;
   localparam int unsigned POS_LEN_LO   = 8;
   localparam int unsigned HEADER_BYTES = 9;
   localparam int unsigned LEN_MIN      = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_BYTE     = 2'd0,
      FUNC_TIMEOUT  = 2'd1,
      FUNC_READ_ERR = 2'd2,
      FUNC_RESERVED = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_TIMEOUT  = 3'd1,
      ST_READ_ERR = 3'd2,
      ST_INVALID  = 3'd3,
      ST_CHECKSUM = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEADER_FIRST  = 2'd0,
      CSR_HEADER_SECOND = 2'd1,
      CSR_ACK_PID       = 2'd2,
      CSR_PARAM_CAP     = 2'd3
   } csr_index_type;

   localparam logic [BYTE_W-1:0] HEADER_FIRST_RESET  = 8'd239;
   localparam logic [BYTE_W-1:0] HEADER_SECOND_RESET = 8'd1;
   localparam logic [BYTE_W-1:0] ACK_PID_RESET       = 8'd7;
   localparam logic [BYTE_W-1:0] PARAM_CAP_RESET     = 8'd244;

   typedef struct packed {
      logic              is_status;
      logic [BYTE_W-1:0] param_byte;
      logic [BYTE_W-1:0] param_index;
      status_type        status;
      logic [BYTE_W-1:0] confirm_code;
      logic [BYTE_W-1:0] param_count;
   } rsp_type;

   function automatic rsp_type status_item(status_type st, logic [BYTE_W-1:0] code,
                                           logic [BYTE_W-1:0] count);
      rsp_type r;
      r              = '0;
      r.is_status    = 1'b1;
      r.status       = st;
      r.confirm_code = code;
      r.param_count  = count;
      return r;
   endfunction

endpackage

/* design/apd_ifs.sv */
// ----------------------------------------------------------------------------
// apd channel interfaces
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
interface apd_req_if;
   logic                         valid;
   logic                         ready;
   logic [apd_pkg::FUNC_W-1:0]   func;
   logic [apd_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, func, rx_byte, input ready);
   modport sink   (input valid, func, rx_byte, output ready);
endinterface

interface apd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           is_status;
   logic [apd_pkg::BYTE_W-1:0]     param_byte;
   logic [apd_pkg::BYTE_W-1:0]     param_index;
   logic [apd_pkg::STATUS_W-1:0]   status;
   logic [apd_pkg::BYTE_W-1:0]     confirm_code;
   logic [apd_pkg::BYTE_W-1:0]     param_count;

   modport source (output valid, is_status, param_byte, param_index, status,
                   confirm_code, param_count, input ready);
   modport sink   (input valid, is_status, param_byte, param_index, status,
                   confirm_code, param_count, output ready);
endinterface

/* design/ack_packet_deframer.sv */
// ----------------------------------------------------------------------------
// ack_packet_deframer
// Parses acknowledge packets byte by byte and reports parameters and status.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one transaction per received byte (func 0) or a read
//   timeout / read error event (func 1 / 2); func 3 is dropped silently.
//   rsp_chan returns one transaction per parameter byte as it arrives, and
//   one status transaction at the end of each packet (ok, timeout, read
//   error, invalid header/PID/length, checksum mismatch).
//   csr_we/csr_index/csr_wdata set the expected header bytes, PID and the
//   parameter capacity; write them only while the block is idle.
//   Throughput: one transaction per cycle on req_chan while ready is high.
//   The per-byte parse is one compare and one 16-bit add between the
//   state registers and the result register.
//   Each result is registered before it is valid on rsp_chan.
//   A two-entry output buffer (result register plus skid register) keeps
//   req_chan.ready high while one result waits; ready drops only when both
//   entries are full.
//   Reset (synchronous, active high) restores register defaults, empties
//   the output buffer and waits for the first header byte.
// ----------------------------------------------------------------------------
module ack_packet_deframer #(
   parameter int unsigned MAX_PACKET_BYTES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   apd_req_if.sink                           req_chan,
   apd_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [apd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [apd_pkg::BYTE_W-1:0]        csr_wdata
);

   localparam int unsigned POS_W   = $clog2(MAX_PACKET_BYTES);
   localparam int unsigned LEN_MAX = MAX_PACKET_BYTES - apd_pkg::HEADER_BYTES;

   // configuration
   logic [apd_pkg::BYTE_W-1:0] hdr_first_ff, hdr_second_ff, ack_pid_ff, param_cap_ff;

   // parse state
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic                       hok_ff, hok_in;
   logic [15:0]                len_ff, len_in;
   logic [15:0]                sum_ff, sum_in;
   logic [apd_pkg::BYTE_W-1:0] code_ff, code_in;
   logic [apd_pkg::BYTE_W-1:0] chk_hi_ff, chk_hi_in;

   // output buffer
   logic                       out_v_ff, out_v_in;
   apd_pkg::rsp_type           out_ff, out_in;
   logic                       skid_v_ff, skid_v_in;
   apd_pkg::rsp_type           skid_ff, skid_in;

   logic                       req_fire, rsp_fire, produce, restart;
   apd_pkg::rsp_type           res;
   apd_pkg::func_type          func;
   logic [apd_pkg::BYTE_W-1:0] b;
   logic [POS_W-1:0]           c, c_m1;
   logic [16:0]                c_plus2, len_ext;
   logic [15:0]                len_chk, rx_sum, n_param;

   assign req_chan.ready = !skid_v_ff;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = out_v_ff && rsp_chan.ready;
   assign func           = apd_pkg::func_type'(req_chan.func);
   assign b              = req_chan.rx_byte;

   assign c       = pos_ff - POS_W'(apd_pkg::HEADER_BYTES);
   assign c_m1    = c - POS_W'(1);
   assign c_plus2 = 17'(c) + 17'd2;
   assign len_ext = {1'b0, len_ff};
   assign len_chk = {len_ff[15:8], b};
   assign rx_sum  = {chk_hi_ff, b};
   assign n_param = len_ff - 16'(apd_pkg::LEN_MIN);

   always_comb begin
      pos_in    = pos_ff;
      hok_in    = hok_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      code_in   = code_ff;
      chk_hi_in = chk_hi_ff;
      produce   = 1'b0;
      restart   = 1'b0;
      res       = '0;
      if (req_fire) begin
         unique case (func)
            apd_pkg::FUNC_TIMEOUT: begin
               produce = 1'b1;
               restart = 1'b1;
               res     = apd_pkg::status_item(apd_pkg::ST_TIMEOUT, '0, '0);
            end
            apd_pkg::FUNC_READ_ERR: begin
               produce = 1'b1;
               restart = 1'b1;
               res     = apd_pkg::status_item(apd_pkg::ST_READ_ERR, '0, '0);
            end
            apd_pkg::FUNC_BYTE: begin
               pos_in = pos_ff + POS_W'(1);
               if (pos_ff < POS_W'(apd_pkg::HEADER_BYTES)) begin
                  priority if (pos_ff == POS_W'(apd_pkg::POS_HDR0)) begin
                     hok_in = (b == hdr_first_ff);
                  end else if (pos_ff == POS_W'(apd_pkg::POS_HDR1)) begin
                     hok_in = hok_ff && (b == hdr_second_ff);
                  end else if (pos_ff == POS_W'(apd_pkg::POS_PID)) begin
                     hok_in = hok_ff && (b == ack_pid_ff);
                     sum_in = 16'(b);
                  end else if (pos_ff == POS_W'(apd_pkg::POS_LEN_HI)) begin
                     len_in = {b, 8'd0};
                     sum_in = sum_ff + 16'(b);
                  end else if (pos_ff == POS_W'(apd_pkg::POS_LEN_LO)) begin
                     len_in = len_chk;
                     sum_in = sum_ff + 16'(b);
                     if (!hok_ff || len_chk < 16'(apd_pkg::LEN_MIN) ||
                         len_chk > 16'(LEN_MAX)) begin
                        produce = 1'b1;
                        restart = 1'b1;
                        res = apd_pkg::status_item(apd_pkg::ST_INVALID, '0, '0);
                     end
                  end else begin
                     // address bytes are skipped
                     hok_in = hok_ff;
                  end
               end else begin
                  priority if (c == '0) begin
                     code_in = b;
                     sum_in  = sum_ff + 16'(b);
                  end else if (c_plus2 < len_ext) begin
                     sum_in          = sum_ff + 16'(b);
                     produce         = 1'b1;
                     res.param_byte  = b;
                     res.param_index = 8'(c_m1);
                  end else if (c_plus2 == len_ext) begin
                     chk_hi_in = b;
                  end else begin
                     produce = 1'b1;
                     restart = 1'b1;
                     if (rx_sum != sum_ff) begin
                        res = apd_pkg::status_item(apd_pkg::ST_CHECKSUM, '0, '0);
                     end else if (n_param > 16'(param_cap_ff)) begin
                        res = apd_pkg::status_item(apd_pkg::ST_OK, code_ff, '0);
                     end else begin
                        res = apd_pkg::status_item(apd_pkg::ST_OK, code_ff,
                                                   n_param[7:0]);
                     end
                  end
               end
            end
            default: begin
               // reserved code: no result, state holds
               produce = 1'b0;
            end
         endcase
         if (restart) begin
            pos_in    = '0;
            hok_in    = 1'b1;
            len_in    = '0;
            sum_in    = '0;
            code_in   = '0;
            chk_hi_in = '0;
         end
      end
   end

   // result register plus skid entry
   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (rsp_fire || !out_v_ff) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = produce;
            out_in   = res;
         end
      end else if (produce) begin
         skid_v_in = 1'b1;
         skid_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_first_ff  <= apd_pkg::HEADER_FIRST_RESET;
         hdr_second_ff <= apd_pkg::HEADER_SECOND_RESET;
         ack_pid_ff    <= apd_pkg::ACK_PID_RESET;
         param_cap_ff  <= apd_pkg::PARAM_CAP_RESET;
         pos_ff        <= '0;
         hok_ff        <= 1'b1;
         len_ff        <= '0;
         sum_ff        <= '0;
         code_ff       <= '0;
         chk_hi_ff     <= '0;
         out_v_ff      <= 1'b0;
         skid_v_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (apd_pkg::csr_index_type'(csr_index))
               apd_pkg::CSR_HEADER_FIRST:  hdr_first_ff  <= csr_wdata;
               apd_pkg::CSR_HEADER_SECOND: hdr_second_ff <= csr_wdata;
               apd_pkg::CSR_ACK_PID:       ack_pid_ff    <= csr_wdata;
               apd_pkg::CSR_PARAM_CAP:     param_cap_ff  <= csr_wdata;
               default:                    param_cap_ff  <= param_cap_ff;
            endcase
         end
         pos_ff    <= pos_in;
         hok_ff    <= hok_in;
         len_ff    <= len_in;
         sum_ff    <= sum_in;
         code_ff   <= code_in;
         chk_hi_ff <= chk_hi_in;
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.is_status    = out_ff.is_status;
   assign rsp_chan.param_byte   = out_ff.param_byte;
   assign rsp_chan.param_index  = out_ff.param_index;
   assign rsp_chan.status       = out_ff.status;
   assign rsp_chan.confirm_code = out_ff.confirm_code;
   assign rsp_chan.param_count  = out_ff.param_count;

   // skid entry only fills behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry valid with empty result register");

   // timeout or read error always returns to the first header byte
   a_abort_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (func == apd_pkg::FUNC_TIMEOUT || func == apd_pkg::FUNC_READ_ERR))
      |=> (pos_ff == '0 && hok_ff))
      else $error("abort transaction did not restart the packet");

   // a failing status carries no code and no count
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_ff.is_status && out_ff.status != apd_pkg::ST_OK)
      |-> (out_ff.confirm_code == '0 && out_ff.param_count == '0))
      else $error("failing status with nonzero code or count");

   // position stays inside the largest packet
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < MAX_PACKET_BYTES)
      else $error("byte position beyond packet limit");

   // a stalled result does not get overwritten
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_chan.ready) |=> (out_v_ff && out_ff == $past(out_ff)))
      else $error("stalled result changed");

endmodule
